### design/plle_pkg.sv
package plle_pkg;

	// Pool geometry
	localparam int POOL_NODES = 16;
	localparam int AW         = $clog2(POOL_NODES);
	localparam int IW         = $clog2(POOL_NODES + 1);
	localparam int WORD_W     = 32;
	localparam int POS_W      = 4;

	localparam logic [IW-1:0]     NONE_IDX = IW'(POOL_NODES);
	localparam logic [WORD_W-1:0] CLEARED  = '1;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_READ   = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_NO_SUCC = 2'd3
	} status_t;

	// Node payload as held in the data memory
	typedef struct packed {
		logic signed [WORD_W-1:0] grade;
		logic signed [WORD_W-1:0] id;
	} node_data_t;

	// Input beat payload, first field in the highest bits
	typedef struct packed {
		logic signed [WORD_W-1:0] grade;
		logic signed [WORD_W-1:0] student_id;
		logic [POS_W-1:0]         position;
		logic                     at_front;
	} in_data_t;

	// Output beat payload, first field in the highest bits
	typedef struct packed {
		logic [IW-1:0]            free_head;
		logic [IW-1:0]            list_head;
		logic [IW-1:0]            node_link;
		logic signed [WORD_W-1:0] node_grade;
		logic signed [WORD_W-1:0] node_id;
		logic [IW-1:0]            node_index;
	} out_data_t;

	localparam int IN_BITS   = $bits(in_data_t);
	localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = $bits(out_data_t);
	localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

	// Link value of an entry that was never written
	function automatic logic [IW-1:0] link_reset(input logic [AW-1:0] a);
		logic [IW-1:0] nxt;
		nxt = IW'(a) + IW'(1);
		return (a == AW'(POOL_NODES - 1)) ? NONE_IDX : nxt;
	endfunction

endpackage

### design/plle_ram.sv
module plle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry with registered data (old value on collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/pool_linked_list_engine.sv
// Sequence: an error or no-op goes from S_IDLE to S_DONE; front insert, front delete and read
//   pass S_R1; insert or delete after a given node passes S_R1, S_R2 and S_W (a delete with no
//   successor stops after S_R1). The result beat is registered from S_DONE. One item at a time;
//   the single read and single write port of the link memory set the step count of each operation.
// Reset: list empty, free list 0..POOL_NODES-1 in order; per-entry valid bits clear at
//   once so untouched entries read as id/grade -1 and link i+1. No clearing pass.
module pool_linked_list_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// at_front, position, student_id, grade (low to high), zero pad
	input  logic [plle_pkg::IN_TDATA-1:0]   s_tdata,
	// mode
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// node_index, node_id, node_grade, node_link, list_head, free_head (low to high), pad
	output logic [plle_pkg::OUT_TDATA-1:0]  m_tdata,
	// status
	output logic [1:0]                      m_tuser
);

	localparam int AW = plle_pkg::AW;
	localparam int IW = plle_pkg::IW;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_R1   = 5'b00010,
		S_R2   = 5'b00100,
		S_W    = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	typedef struct packed {
		plle_pkg::status_t  status;
		logic [IW-1:0]      index;
		plle_pkg::node_data_t data;
		logic [IW-1:0]      link;
	} res_t;

	function automatic res_t res_err(input plle_pkg::status_t st);
		res_t r;
		r.status     = st;
		r.index      = plle_pkg::NONE_IDX;
		r.data.id    = '0;
		r.data.grade = '0;
		r.link       = plle_pkg::NONE_IDX;
		return r;
	endfunction

	state_t                state_q, state_d;
	logic [IW-1:0]         head_q, head_d, free_q, free_d;
	logic [IW-1:0]         nf_q, nf_d;
	logic [AW-1:0]         node_q, node_d;
	plle_pkg::mode_t       mode_q;
	logic                  front_q;
	logic [AW-1:0]         pos_q;
	plle_pkg::node_data_t  ins_q;
	res_t                  res_q, res_d;
	logic [plle_pkg::POOL_NODES-1:0] link_vld_q, data_vld_q;
	logic                  lvld_s1, dvld_s1;
	logic [AW-1:0]         raddr_s1;
	logic                  out_vld_q;

	plle_pkg::in_data_t    in_d;
	plle_pkg::mode_t       in_mode;
	logic [AW-1:0]         in_pos;
	logic                  in_pos_ok;
	logic                  accept;

	logic [AW-1:0]         raddr;
	logic                  link_we, data_we;
	logic [AW-1:0]         link_waddr, data_waddr;
	logic [IW-1:0]         link_wdata, link_rdata, rd_link;
	plle_pkg::node_data_t  data_wdata, data_rdata, rd_data, cleared_data;
	plle_pkg::out_data_t   out_d;

	// Unpack the input beat
	assign in_d      = plle_pkg::in_data_t'(s_tdata[plle_pkg::IN_BITS-1:0]);
	assign in_mode   = plle_pkg::mode_t'(s_tuser);
	assign in_pos    = AW'(in_d.position);
	assign in_pos_ok = (IW'(in_d.position) < plle_pkg::NONE_IDX);
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;

	assign cleared_data.id    = plle_pkg::CLEARED;
	assign cleared_data.grade = plle_pkg::CLEARED;

	// Substitute reset values for entries never written
	assign rd_link = lvld_s1 ? link_rdata : plle_pkg::link_reset(raddr_s1);
	assign rd_data = dvld_s1 ? data_rdata : cleared_data;

	plle_ram #(.WIDTH(IW), .DEPTH(plle_pkg::POOL_NODES)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (raddr),
		.rdata (link_rdata)
	);

	plle_ram #(.WIDTH($bits(plle_pkg::node_data_t)), .DEPTH(plle_pkg::POOL_NODES)) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (data_waddr),
		.wdata (data_wdata),
		.raddr (raddr),
		.rdata (data_rdata)
	);

	// Sequencer: read, modify, write back
	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		free_d     = free_q;
		nf_d       = nf_q;
		node_d     = node_q;
		res_d      = res_q;
		raddr      = node_q;
		link_we    = 1'b0;
		link_waddr = node_q;
		link_wdata = head_q;
		data_we    = 1'b0;
		data_waddr = node_q;
		data_wdata = ins_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_R1;
					case (in_mode)
						plle_pkg::MODE_INSERT: begin
							raddr  = free_q[AW-1:0];
							node_d = free_q[AW-1:0];
							if (free_q == plle_pkg::NONE_IDX) begin
								res_d   = res_err(plle_pkg::ST_FULL);
								state_d = S_DONE;
							end else if (!in_d.at_front && !in_pos_ok) begin
								res_d   = res_err(plle_pkg::ST_NO_SUCC);
								state_d = S_DONE;
							end
						end
						plle_pkg::MODE_DELETE: begin
							raddr  = in_d.at_front ? head_q[AW-1:0] : in_pos;
							node_d = head_q[AW-1:0];
							if (head_q == plle_pkg::NONE_IDX) begin
								res_d   = res_err(plle_pkg::ST_EMPTY);
								state_d = S_DONE;
							end else if (!in_d.at_front && !in_pos_ok) begin
								res_d   = res_err(plle_pkg::ST_NO_SUCC);
								state_d = S_DONE;
							end
						end
						plle_pkg::MODE_READ: begin
							raddr = in_pos;
							if (!in_pos_ok) begin
								res_d   = res_err(plle_pkg::ST_NO_SUCC);
								state_d = S_DONE;
							end
						end
						default: begin
							res_d   = res_err(plle_pkg::ST_OK);
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_R1: begin
				state_d = S_DONE;
				case (mode_q)
					plle_pkg::MODE_INSERT: begin
						nf_d = rd_link;
						res_d.status = plle_pkg::ST_OK;
						res_d.index  = IW'(node_q);
						res_d.data   = ins_q;
						if (front_q) begin
							link_we    = 1'b1;
							link_wdata = head_q;
							data_we    = 1'b1;
							head_d     = IW'(node_q);
							free_d     = rd_link;
							res_d.link = head_q;
						end else begin
							raddr   = pos_q;
							state_d = S_R2;
						end
					end
					plle_pkg::MODE_DELETE: begin
						if (front_q) begin
							link_we      = 1'b1;
							link_wdata   = free_q;
							data_we      = 1'b1;
							data_wdata   = cleared_data;
							head_d       = rd_link;
							free_d       = IW'(node_q);
							res_d.status = plle_pkg::ST_OK;
							res_d.index  = IW'(node_q);
							res_d.data   = rd_data;
							res_d.link   = free_q;
						end else if (rd_link == plle_pkg::NONE_IDX) begin
							res_d = res_err(plle_pkg::ST_NO_SUCC);
						end else begin
							node_d  = rd_link[AW-1:0];
							raddr   = rd_link[AW-1:0];
							state_d = S_R2;
						end
					end
					plle_pkg::MODE_READ: begin
						res_d.status = plle_pkg::ST_OK;
						res_d.index  = IW'(pos_q);
						res_d.data   = rd_data;
						res_d.link   = rd_link;
					end
					default: begin
						res_d = res_err(plle_pkg::ST_OK);
					end
				endcase
			end
			S_R2: begin
				state_d = S_W;
				case (mode_q)
					plle_pkg::MODE_INSERT: begin
						// New node takes the predecessor's old successor
						link_we    = 1'b1;
						link_wdata = rd_link;
						data_we    = 1'b1;
						res_d.link = (pos_q == node_q) ? IW'(node_q) : rd_link;
					end
					plle_pkg::MODE_DELETE: begin
						// Bypass the removed node and clear its payload
						link_we      = 1'b1;
						link_waddr   = pos_q;
						link_wdata   = rd_link;
						data_we      = 1'b1;
						data_wdata   = cleared_data;
						res_d.status = plle_pkg::ST_OK;
						res_d.index  = IW'(node_q);
						res_d.data   = rd_data;
						res_d.link   = free_q;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_W: begin
				state_d = S_DONE;
				case (mode_q)
					plle_pkg::MODE_INSERT: begin
						link_we    = 1'b1;
						link_waddr = pos_q;
						link_wdata = IW'(node_q);
						free_d     = nf_q;
					end
					plle_pkg::MODE_DELETE: begin
						link_we    = 1'b1;
						link_wdata = free_q;
						free_d     = IW'(node_q);
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_DONE: begin
				if (!out_vld_q || m_tready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= plle_pkg::NONE_IDX;
			free_q     <= '0;
			link_vld_q <= '0;
			data_vld_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			free_q  <= free_d;
			if (link_we) begin
				link_vld_q[link_waddr] <= 1'b1;
			end
			if (data_we) begin
				data_vld_q[data_waddr] <= 1'b1;
			end
			if (state_q == S_DONE && (!out_vld_q || m_tready)) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Output beat fields
	assign out_d.node_index = res_q.index;
	assign out_d.node_id    = res_q.data.id;
	assign out_d.node_grade = res_q.data.grade;
	assign out_d.node_link  = res_q.link;
	assign out_d.list_head  = head_q;
	assign out_d.free_head  = free_q;

	// Payload and read-side registers
	always_ff @(posedge clk) begin
		nf_q     <= nf_d;
		node_q   <= node_d;
		res_q    <= res_d;
		raddr_s1 <= raddr;
		lvld_s1  <= link_vld_q[raddr];
		dvld_s1  <= data_vld_q[raddr];
		if (accept) begin
			mode_q         <= in_mode;
			front_q        <= in_d.at_front;
			pos_q          <= in_pos;
			ins_q.id       <= in_d.student_id;
			ins_q.grade    <= in_d.grade;
		end
		if (state_q == S_DONE && (!out_vld_q || m_tready)) begin
			m_tdata <= plle_pkg::OUT_TDATA'(out_d);
			m_tuser <= res_q.status;
		end
	end

	assign m_tvalid = out_vld_q;

endmodule

### design/plle_checker.sv
module plle_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [plle_pkg::IN_TDATA-1:0]  s_tdata,
	input logic [1:0]                     s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [plle_pkg::OUT_TDATA-1:0] m_tdata,
	input logic [1:0]                     m_tuser
);

	localparam int IW = plle_pkg::IW;

	logic [IW-1:0] o_index, o_link, o_head, o_free;

	assign o_index = m_tdata[IW-1:0];
	assign o_link  = m_tdata[IW+2*plle_pkg::WORD_W +: IW];
	assign o_head  = m_tdata[2*IW+2*plle_pkg::WORD_W +: IW];
	assign o_free  = m_tdata[3*IW+2*plle_pkg::WORD_W +: IW];

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// Take one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in flight");

	// Report no node on an error
	a_err_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != plle_pkg::ST_OK |->
			o_index == plle_pkg::NONE_IDX && o_link == plle_pkg::NONE_IDX)
		else $error("error result reports a node");

	// Keep list and free list disjoint at the head
	a_heads_apart: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> o_head != o_free || o_head == plle_pkg::NONE_IDX)
		else $error("list head and free head coincide");

	// Answer only after an item was taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !s_tready || $past(s_tvalid && s_tready, 2)
			|| $past(!s_tready))
		else $error("result beat without an item");

endmodule

bind pool_linked_list_engine plle_checker u_plle_checker (.*);

### tb/sv/pool_linked_list_engine_tb.sv
`timescale 1ns / 100ps

module pool_linked_list_engine_tb;

	import plle_pkg::*;

	// One expected result beat: status plus the unpacked tdata fields
	typedef struct {
		status_t       status;
		logic [IW-1:0] idx;
		logic [31:0]   id;
		logic [31:0]   grade;
		logic [IW-1:0] link;
		logic [IW-1:0] head;
		logic [IW-1:0] free;
	} node_report_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_TDATA-1:0]  s_tdata  = '0;
	logic [1:0]           s_tuser  = MODE_NOP;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_TDATA-1:0] m_tdata;
	logic [1:0]           m_tuser;

	// Shadow copy of the pool, kept in step with accepted beats
	logic [31:0]   pool_id    [POOL_NODES];
	logic [31:0]   pool_grade [POOL_NODES];
	logic [IW-1:0] pool_link  [POOL_NODES];
	logic [IW-1:0] list_top;
	logic [IW-1:0] free_top;

	node_report_t report_q[$];
	int           mismatches = 0;
	bit           quiet      = 1'b0;
	int           rx_wait    = 0;

	pool_linked_list_engine i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("pool_linked_list_engine_tb: FAIL");
		$finish;
	end

	// Apply one operation to the shadow pool and queue the result it causes
	task automatic predict_step(input mode_t m, input logic front, input logic [3:0] pos,
			input logic [31:0] sid, input logic [31:0] grd);
		node_report_t r;
		logic [AW-1:0] node;
		bit            moved;
		bit            pos_ok;
		r.status = ST_OK;
		r.idx    = NONE_IDX;
		r.id     = '0;
		r.grade  = '0;
		r.link   = NONE_IDX;
		moved    = 1'b0;
		pos_ok   = int'(pos) < POOL_NODES;
		case (m)
			MODE_INSERT: begin
				if (free_top >= NONE_IDX) begin
					r.status = ST_FULL;
				end else if (!front && !pos_ok) begin
					r.status = ST_NO_SUCC;
				end else begin
					node             = free_top[AW-1:0];
					free_top         = pool_link[node];
					pool_id[node]    = sid;
					pool_grade[node] = grd;
					if (front) begin
						pool_link[node] = list_top;
						list_top        = IW'(node);
					end else begin
						pool_link[node] = pool_link[pos];
						pool_link[pos]  = IW'(node);
					end
					r.idx   = IW'(node);
					r.id    = sid;
					r.grade = grd;
					r.link  = pool_link[node];
				end
			end
			MODE_DELETE: begin
				if (list_top >= NONE_IDX) begin
					r.status = ST_EMPTY;
				end else if (front) begin
					node     = list_top[AW-1:0];
					list_top = pool_link[node];
					moved    = 1'b1;
				end else if (!pos_ok || pool_link[pos] >= NONE_IDX) begin
					r.status = ST_NO_SUCC;
				end else begin
					node           = pool_link[pos][AW-1:0];
					pool_link[pos] = pool_link[node];
					moved          = 1'b1;
				end
				// Unlink done: hand the node back to the free list and clear it
				if (moved) begin
					r.id             = pool_id[node];
					r.grade          = pool_grade[node];
					pool_link[node]  = free_top;
					pool_id[node]    = CLEARED;
					pool_grade[node] = CLEARED;
					free_top         = IW'(node);
					r.idx            = IW'(node);
					r.link           = pool_link[node];
				end
			end
			MODE_READ: begin
				if (!pos_ok) begin
					r.status = ST_NO_SUCC;
				end else begin
					r.idx   = IW'(pos);
					r.id    = pool_id[pos];
					r.grade = pool_grade[pos];
					r.link  = pool_link[pos];
				end
			end
			default: ;
		endcase
		r.head = list_top;
		r.free = free_top;
		report_q.push_back(r);
	endtask

	// Drive one input beat after a random gap and hold it until accepted
	task automatic send_item(input mode_t m, input logic front, input logic [3:0] pos,
			input logic [31:0] sid, input logic [31:0] grd);
		in_data_t beat;
		int       gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		beat.at_front   = front;
		beat.position   = pos;
		beat.student_id = sid;
		beat.grade      = grd;
		s_tdata  <= IN_TDATA'(beat);
		s_tuser  <= m;
		s_tvalid <= 1'b1;
		predict_step(m, front, pos, sid, grd);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result(input logic [1:0] st, input out_data_t got);
		node_report_t want;
		if (report_q.size() == 0) begin
			$display("%0t: unexpected result beat, expected none, actual status %h data %h",
				$time, st, got);
			mismatches++;
		end else begin
			want = report_q.pop_front();
			check_field("status",     want.status, st);
			check_field("node_index", want.idx,    got.node_index);
			check_field("node_id",    want.id,     got.node_id);
			check_field("node_grade", want.grade,  got.node_grade);
			check_field("node_link",  want.link,   got.node_link);
			check_field("list_head",  want.head,   got.list_head);
			check_field("free_head",  want.free,   got.free_head);
		end
	endtask

	// Result side: check each accepted beat, then stall a random number of cycles
	always @(posedge clk or negedge arst_n) begin : result_side
		int nxt;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait  <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result(m_tuser, m_tdata[OUT_BITS-1:0]);
				nxt = quiet ? 0 : $urandom_range(0, 4);
			end else begin
				nxt = (rx_wait > 0) ? rx_wait - 1 : 0;
			end
			rx_wait  <= nxt;
			m_tready <= (nxt == 0);
		end
	end

	// Word with a bias toward the signed extremes
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Walk a random distance down the shadow list; NONE_IDX when empty
	function automatic logic [IW-1:0] pick_on_list();
		logic [IW-1:0] cur;
		int            steps;
		cur   = list_top;
		steps = $urandom_range(0, POOL_NODES - 1);
		while (steps > 0 && cur < NONE_IDX && pool_link[cur[AW-1:0]] < NONE_IDX) begin
			cur = pool_link[cur[AW-1:0]];
			steps--;
		end
		return cur;
	endfunction

	// Reset contents, operations on an empty list, and the no-op mode
	task automatic test_reset_state();
		send_item(MODE_READ,   1'b0, 4'd0,  rand_word(), rand_word());
		send_item(MODE_READ,   1'b0, 4'd15, rand_word(), rand_word());
		send_item(MODE_DELETE, 1'b1, 4'd0,  rand_word(), rand_word());
		send_item(MODE_DELETE, 1'b0, 4'd5,  rand_word(), rand_word());
		send_item(MODE_NOP,    1'b1, 4'd15, 32'hffff_ffff, 32'hffff_ffff);
	endtask

	// Front and after-node edits on a short list, including a delete past the tail
	task automatic test_list_edits();
		send_item(MODE_INSERT, 1'b1, 4'd15, 32'h8000_0000, 32'h7fff_ffff);
		send_item(MODE_INSERT, 1'b0, 4'd0,  32'h7fff_ffff, 32'h8000_0000);
		send_item(MODE_DELETE, 1'b0, 4'd1,  rand_word(),   rand_word());
		send_item(MODE_INSERT, 1'b1, 4'd7,  32'h0000_0000, 32'hffff_ffff);
		send_item(MODE_READ,   1'b1, 4'd0,  rand_word(),   rand_word());
		send_item(MODE_DELETE, 1'b0, 4'd2,  rand_word(),   rand_word());
		send_item(MODE_READ,   1'b0, 4'd0,  rand_word(),   rand_word());
		send_item(MODE_DELETE, 1'b1, 4'd9,  rand_word(),   rand_word());
		send_item(MODE_DELETE, 1'b0, 4'd1,  rand_word(),   rand_word());
		send_item(MODE_INSERT, 1'b0, 4'd1,  32'hffff_ffff, 32'h0000_0000);
		send_item(MODE_DELETE, 1'b1, 4'd0,  rand_word(),   rand_word());
		send_item(MODE_DELETE, 1'b1, 4'd0,  rand_word(),   rand_word());
		send_item(MODE_DELETE, 1'b1, 4'd0,  rand_word(),   rand_word());
	endtask

	// Fill the pool past full, then drain it past empty
	task automatic test_fill_drain(input int rounds);
		logic [IW-1:0] pred;
		bit            front;
		for (int r = 0; r < rounds; r++) begin
			quiet = r[0];
			for (int i = 0; i < POOL_NODES + 2; i++) begin
				pred  = pick_on_list();
				front = (pred >= NONE_IDX) || ($urandom_range(0, 1) == 0);
				send_item(MODE_INSERT, front, front ? 4'($urandom) : pred[3:0],
					rand_word(), rand_word());
			end
			for (int i = 0; i < POOL_NODES + 2; i++) begin
				pred  = pick_on_list();
				front = (pred >= NONE_IDX) || ($urandom_range(0, 1) == 0);
				send_item(MODE_DELETE, front, front ? 4'($urandom) : pred[3:0],
					rand_word(), rand_word());
			end
		end
		quiet = 1'b0;
	endtask

	// Well-formed traffic: predecessors always taken from the list
	task automatic test_random_ops(input int n_items);
		int            bias;
		int            pick;
		logic [IW-1:0] pred;
		bit            front;
		for (int i = 0; i < n_items; i++) begin
			// Swing between filling and draining so both ends are hit often
			if (i % 100 == 0) begin
				case ($urandom_range(0, 2))
					0:       bias = 15;
					1:       bias = 50;
					default: bias = 85;
				endcase
				quiet = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			pred = pick_on_list();
			if (pick < 12) begin
				send_item(MODE_READ, 1'($urandom), 4'($urandom), rand_word(), rand_word());
			end else if (pick < 15) begin
				send_item(MODE_NOP, 1'($urandom), 4'($urandom), rand_word(), rand_word());
			end else begin
				front = (pred >= NONE_IDX) || ($urandom_range(0, 2) == 0);
				send_item(($urandom_range(0, 99) < bias) ? MODE_INSERT : MODE_DELETE, front,
					front ? 4'($urandom) : pred[3:0], rand_word(), rand_word());
			end
		end
		quiet = 1'b0;
	endtask

	// Unconstrained beats, predecessors anywhere in the pool
	task automatic test_noise(input int n_items);
		for (int i = 0; i < n_items; i++) begin
			quiet = (i >= n_items / 2) && (i < n_items * 3 / 4);
			send_item(mode_t'($urandom_range(0, 3)), 1'($urandom), 4'($urandom),
				rand_word(), rand_word());
		end
		quiet = 1'b0;
	endtask

	initial begin
		int wait_cycles;
		for (int i = 0; i < POOL_NODES; i++) begin
			pool_id[i]    = CLEARED;
			pool_grade[i] = CLEARED;
			pool_link[i]  = link_for_reset(i);
		end
		list_top = NONE_IDX;
		free_top = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_list_edits();
		test_fill_drain(2);
		test_random_ops(1450);
		test_noise(350);
		s_tvalid <= 1'b0;

		// Drain outstanding results, then allow a few extra cycles for strays
		wait_cycles = 0;
		while (report_q.size() != 0 && wait_cycles < 2000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (12) @(posedge clk);

		if (mismatches == 0 && report_q.size() == 0) begin
			$display("pool_linked_list_engine_tb: PASS");
		end else begin
			$display("pool_linked_list_engine_tb: FAIL");
		end
		$finish;
	end

	// Free list at reset runs 0, 1, ... in order; the last node has no successor
	function automatic logic [IW-1:0] link_for_reset(input int i);
		return (i == POOL_NODES - 1) ? NONE_IDX : IW'(i + 1);
	endfunction

endmodule
